// ===== hdl/dsv_pkg.sv =====
// Shared types, character codes and month table for the date string validator.
package dsv_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned ACC_W   = 7;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1901;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] LEN_MIN = 4'd8;
	localparam logic [3:0] LEN_MAX = 4'd10;
	localparam logic [3:0] LEN_SAT = 4'd15;

	localparam logic [ACC_W-1:0] MONTH_MAX = 7'd12;
	localparam logic [4:0]       FEB_LEAP  = 5'd29;
	localparam logic [ACC_W-1:0] MONTH_FEB = 7'd2;

	typedef enum logic [2:0] {
		PH_D1,
		PH_D2,
		PH_S1,
		PH_M1,
		PH_M2,
		PH_S2,
		PH_Y,
		PH_DONE
	} phase_t;

	// days in a common year for months 1..12
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd2:                      d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// ===== hdl/dsv_if.sv =====
// Channel interfaces: character input, date result and configuration write.
interface dsv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface dsv_res_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [4:0]  day;
	logic [3:0]  month;
	logic [13:0] year;

	modport source (output valid, output valid_res, output day, output month, output year,
		input ready);
	modport sink (input valid, input valid_res, input day, input month, input year,
		output ready);
endinterface

interface dsv_cfg_if;
	logic        valid;
	logic        ready;
	logic [13:0] min_year;

	modport source (output valid, output min_year, input ready);
	modport sink (input valid, input min_year, output ready);
endinterface

// ===== hdl/date_string_validator.sv =====
// Streaming day-month-year date string validator, top level.
// Characters enter one per cycle on char_ch; each transaction is captured in an input
// register and the parse state is advanced from it in the following cycle, so a new
// character is taken every cycle while the result register is free or being drained.
// The transaction flagged with last_char produces one registered result on res_ch,
// held back while an earlier result still waits: valid_res with day, month and year,
// or all zeros when the string does not have the form D[D] sep M[M] sep YYYY (sep '/'
// or '-', both the same), is not 8 to 10 characters long, or names an impossible date
// or a year below min_year. Characters after the fourth year digit are only counted.
// The parse restarts cleanly after each last character. The user must write min_year
// (reset 1901) through cfg_ch only while the block is idle; the block does not check.
module date_string_validator
	import dsv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	dsv_char_if.sink        char_ch,
	dsv_res_if.source       res_ch,
	dsv_cfg_if.sink         cfg_ch
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// parse state
	logic [3:0]        count_q;
	phase_t            phase_q;
	logic              dash_q;
	logic [ACC_W-1:0]  day_q;
	logic [ACC_W-1:0]  month_q;
	logic [YEAR_W-1:0] year_q;
	logic [2:0]        ydig_q;
	logic              err_q;
	logic [1:0]        ymod4_q;
	logic [1:0]        cent4_q;
	logic              dzero_q;
	logic              leap_q;

	logic [YEAR_W-1:0] min_year_q;

	// result register
	logic              res_valid_q;
	logic              res_ok_q;
	logic [DAY_W-1:0]  res_day_q;
	logic [MONTH_W-1:0] res_month_q;
	logic [YEAR_W-1:0] res_year_q;

	logic res_free;
	logic fire_s1;

	assign res_free      = !res_valid_q || res_ch.ready;
	assign fire_s1       = valid_s1 && (!last_s1 || res_free);
	assign char_ch.ready = !valid_s1 || fire_s1;
	assign cfg_ch.ready  = 1'b1;

	// next-state logic
	logic              dig;
	logic [3:0]        dv;
	logic              sep;
	logic              is_dash;
	logic              same_sep;
	logic [3:0]        count_n;
	phase_t            phase_n;
	logic              dash_n;
	logic [ACC_W-1:0]  day_n;
	logic [ACC_W-1:0]  month_n;
	logic [YEAR_W-1:0] year_n;
	logic [2:0]        ydig_n;
	logic              err_n;
	logic [1:0]        ymod4_n;
	logic [1:0]        cent4_n;
	logic              dzero_n;
	logic              leap_n;
	logic [YEAR_W-1:0] year_x10;
	logic              hund_zero;

	always_comb begin
		dig      = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		dv       = dig ? 4'(char_s1 - CH_ZERO) : 4'd0;
		is_dash  = (char_s1 == CH_DASH);
		sep      = (char_s1 == CH_SLASH) || is_dash;
		same_sep = sep && (is_dash == dash_q);
		year_x10 = YEAR_W'({year_q, 3'b000}) + YEAR_W'({year_q, 1'b0});
		hund_zero = dzero_q && (dv == 4'd0);

		count_n = (count_q < LEN_SAT) ? count_q + 4'd1 : count_q;
		phase_n = phase_q;
		dash_n  = dash_q;
		day_n   = day_q;
		month_n = month_q;
		year_n  = year_q;
		ydig_n  = ydig_q;
		err_n   = err_q;
		ymod4_n = ymod4_q;
		cent4_n = cent4_q;
		dzero_n = dzero_q;
		leap_n  = leap_q;

		if (!err_q) begin
			unique case (phase_q)
				PH_D1: begin
					if (dig) begin
						day_n   = ACC_W'(dv);
						phase_n = PH_D2;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_D2: begin
					if (dig) begin
						day_n   = ACC_W'({day_q, 3'b000}) + ACC_W'({day_q, 1'b0}) + ACC_W'(dv);
						phase_n = PH_S1;
					end else if (sep) begin
						dash_n  = is_dash;
						phase_n = PH_M1;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_S1: begin
					if (sep) begin
						dash_n  = is_dash;
						phase_n = PH_M1;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_M1: begin
					if (dig) begin
						month_n = ACC_W'(dv);
						phase_n = PH_M2;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_M2: begin
					if (dig) begin
						month_n = ACC_W'({month_q, 3'b000}) + ACC_W'({month_q, 1'b0})
							+ ACC_W'(dv);
						phase_n = PH_S2;
					end else if (same_sep) begin
						phase_n = PH_Y;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_S2: begin
					if (same_sep) begin
						phase_n = PH_Y;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_Y: begin
					if (dig) begin
						year_n  = year_x10 + YEAR_W'(dv);
						ydig_n  = ydig_q + 3'd1;
						// running year mod 4: (10r + d) mod 4 = (2r + d) mod 4
						ymod4_n = {ymod4_q[0], 1'b0} + dv[1:0];
						dzero_n = (dv == 4'd0);
						if (ydig_q == 3'd1) begin
							cent4_n = ymod4_n;
						end
						if (ydig_q == 3'd3) begin
							phase_n = PH_DONE;
							leap_n  = hund_zero ? (cent4_q == 2'd0) : (ymod4_n == 2'd0);
						end
					end else begin
						err_n = 1'b1;
					end
				end
				PH_DONE: begin
				end
				default: begin
					err_n = 1'b1;
				end
			endcase
		end
	end

	// final check on the next-state values
	logic       ok;
	logic [4:0] lim;

	always_comb begin
		lim = month_days(month_n[3:0]);
		if ((month_n == MONTH_FEB) && leap_n) begin
			lim = FEB_LEAP;
		end
		ok = !err_n && (phase_n == PH_DONE)
			&& (count_n >= LEN_MIN) && (count_n <= LEN_MAX)
			&& (month_n != '0) && (month_n <= MONTH_MAX)
			&& (day_n != '0) && (year_n >= min_year_q)
			&& (day_n <= ACC_W'(lim));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.valid && char_ch.ready) begin
			char_s1 <= char_ch.char_in;
			last_s1 <= char_ch.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
		end else if (cfg_ch.valid) begin
			min_year_q <= cfg_ch.min_year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= PH_D1;
			dash_q  <= 1'b0;
			day_q   <= '0;
			month_q <= '0;
			year_q  <= '0;
			ydig_q  <= '0;
			err_q   <= 1'b0;
			ymod4_q <= '0;
			cent4_q <= '0;
			dzero_q <= 1'b0;
			leap_q  <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				// restart the parse for the next string
				count_q <= '0;
				phase_q <= PH_D1;
				dash_q  <= 1'b0;
				day_q   <= '0;
				month_q <= '0;
				year_q  <= '0;
				ydig_q  <= '0;
				err_q   <= 1'b0;
				ymod4_q <= '0;
				cent4_q <= '0;
				dzero_q <= 1'b0;
				leap_q  <= 1'b0;
			end else begin
				count_q <= count_n;
				phase_q <= phase_n;
				dash_q  <= dash_n;
				day_q   <= day_n;
				month_q <= month_n;
				year_q  <= year_n;
				ydig_q  <= ydig_n;
				err_q   <= err_n;
				ymod4_q <= ymod4_n;
				cent4_q <= cent4_n;
				dzero_q <= dzero_n;
				leap_q  <= leap_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			res_ok_q    <= ok;
			res_day_q   <= ok ? day_n[DAY_W-1:0] : '0;
			res_month_q <= ok ? month_n[MONTH_W-1:0] : '0;
			res_year_q  <= ok ? year_n : '0;
		end
	end

	assign res_ch.valid     = res_valid_q;
	assign res_ch.valid_res = res_ok_q;
	assign res_ch.day       = res_day_q;
	assign res_ch.month     = res_month_q;
	assign res_ch.year      = res_year_q;

endmodule

// ===== tb/date_string_validator_tb.sv =====
// Self-checking testbench for the streaming day-month-year date string validator.
module date_string_validator_tb
	import dsv_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_CHARS = 317;
	localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int LEAP_PROBES [9] = '{1600, 1900, 2000, 2100, 2023, 2024, 2400, 9996, 4};

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic [3:0]        count;
		phase_t            ph;
		logic              dash;
		logic [ACC_W-1:0]  d;
		logic [ACC_W-1:0]  m;
		logic [YEAR_W-1:0] y;
		logic [2:0]        ydig;
		logic              err;
	} parse_t;

	typedef struct packed {
		logic               ok;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_res_t;

	logic clk;
	logic arst_n;

	dsv_char_if char_ch ();
	dsv_res_if  res_ch ();
	dsv_cfg_if  cfg_ch ();

	date_string_validator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.char_ch(char_ch),
		.res_ch (res_ch),
		.cfg_ch (cfg_ch)
	);

	char_item_t        chars_pending [$];
	date_res_t         dates_due [$];
	logic [7:0]        str_buf [$];
	char_item_t        next_char;
	parse_t            parse;
	logic [YEAR_W-1:0] min_year_cfg;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                phase_chars;
	int                mismatches;
	int                stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $realtime, msg);
	endtask

	function automatic logic is_leap_year(input logic [YEAR_W-1:0] y);
		if (y % 400 == 0)
			return 1'b1;
		if (y % 100 == 0)
			return 1'b0;
		return (y % 4 == 0);
	endfunction

	// Advance the parse by one accepted character; on the last one, queue the date due.
	task automatic advance_parse(input logic [7:0] c, input logic last);
		logic       dig;
		logic       sep;
		logic       same_sep;
		logic [7:0] dv;
		logic       ok;
		int         lim;
		date_res_t  res;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		dv = dig ? c - CH_ZERO : 8'd0;
		sep = (c == CH_SLASH || c == CH_DASH);
		same_sep = sep && ((c == CH_DASH) == parse.dash);
		if (parse.count != LEN_SAT)
			parse.count = parse.count + 4'd1;
		if (!parse.err) begin
			case (parse.ph)
				PH_D1: begin
					if (dig) begin
						parse.d = {3'b000, dv[3:0]};
						parse.ph = PH_D2;
					end else begin
						parse.err = 1'b1;
					end
				end
				PH_D2: begin
					if (dig) begin
						parse.d = parse.d * 7'd10 + {3'b000, dv[3:0]};
						parse.ph = PH_S1;
					end else if (sep) begin
						parse.dash = (c == CH_DASH);
						parse.ph = PH_M1;
					end else begin
						parse.err = 1'b1;
					end
				end
				PH_S1: begin
					if (sep) begin
						parse.dash = (c == CH_DASH);
						parse.ph = PH_M1;
					end else begin
						parse.err = 1'b1;
					end
				end
				PH_M1: begin
					if (dig) begin
						parse.m = {3'b000, dv[3:0]};
						parse.ph = PH_M2;
					end else begin
						parse.err = 1'b1;
					end
				end
				PH_M2: begin
					if (dig) begin
						parse.m = parse.m * 7'd10 + {3'b000, dv[3:0]};
						parse.ph = PH_S2;
					end else if (same_sep) begin
						parse.ph = PH_Y;
					end else begin
						parse.err = 1'b1;
					end
				end
				PH_S2: begin
					if (same_sep)
						parse.ph = PH_Y;
					else
						parse.err = 1'b1;
				end
				PH_Y: begin
					if (dig) begin
						parse.y = parse.y * 14'd10 + {10'd0, dv[3:0]};
						parse.ydig = parse.ydig + 3'd1;
						if (parse.ydig >= 3'd4)
							parse.ph = PH_DONE;
					end else begin
						parse.err = 1'b1;
					end
				end
				PH_DONE: begin
				end
				default: begin
					parse.err = 1'b1;
				end
			endcase
		end
		if (!last)
			return;
		ok = !parse.err && parse.ph == PH_DONE && parse.count >= LEN_MIN
			&& parse.count <= LEN_MAX && parse.m >= 7'd1 && parse.m <= MONTH_MAX
			&& parse.d >= 7'd1 && parse.y >= min_year_cfg;
		if (ok) begin
			lim = MONTH_LEN[parse.m - 7'd1];
			if (parse.m == MONTH_FEB && is_leap_year(parse.y))
				lim = FEB_LEAP;
			if (parse.d > lim)
				ok = 1'b0;
		end
		res.ok = ok;
		res.day = ok ? parse.d[DAY_W-1:0] : '0;
		res.month = ok ? parse.m[MONTH_W-1:0] : '0;
		res.year = ok ? parse.y : '0;
		dates_due.push_back(res);
		parse = '0;
		parse.ph = PH_D1;
	endtask

	// Character source: present the next pending character unless idling this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_ch.valid <= 1'b0;
			char_ch.char_in <= '0;
			char_ch.last_char <= 1'b0;
		end else begin
			if (char_ch.valid && char_ch.ready)
				advance_parse(char_ch.char_in, char_ch.last_char);
			if (!char_ch.valid || char_ch.ready) begin
				if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_char = chars_pending.pop_front();
					char_ch.valid <= 1'b1;
					char_ch.char_in <= next_char.ch;
					char_ch.last_char <= next_char.last;
				end else begin
					char_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result sink: check each transaction against the oldest date due.
	always @(posedge clk or negedge arst_n) begin
		date_res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (dates_due.size() == 0) begin
					report_mismatch("result with no date due");
				end else begin
					want = dates_due.pop_front();
					if (res_ch.valid_res !== want.ok)
						report_mismatch($sformatf("valid_res %b, want %b",
							res_ch.valid_res, want.ok));
					if (res_ch.day !== want.day)
						report_mismatch($sformatf("day %0d, want %0d", res_ch.day, want.day));
					if (res_ch.month !== want.month)
						report_mismatch($sformatf("month %0d, want %0d",
							res_ch.month, want.month));
					if (res_ch.year !== want.year)
						report_mismatch($sformatf("year %0d, want %0d",
							res_ch.year, want.year));
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// End the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic send_string();
		char_item_t it;
		for (int i = 0; i < str_buf.size(); i++) begin
			it.ch = str_buf[i];
			it.last = (i == str_buf.size() - 1);
			chars_pending.push_back(it);
		end
		phase_chars += str_buf.size();
		str_buf.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			str_buf.push_back(s[i]);
		send_string();
	endtask

	task automatic put_digits(input int v, input int n);
		int div;
		div = 1;
		repeat (n - 1) div *= 10;
		repeat (n) begin
			str_buf.push_back(CH_ZERO + 8'((v / div) % 10));
			div /= 10;
		end
	endtask

	// Mostly well-formed dates with random content; the rest broken, cut short, extended or noise.
	task automatic gen_random_string();
		int         kind;
		int         d;
		int         m;
		int         y;
		int         n;
		int         pos;
		logic [7:0] b;
		logic [7:0] sep;
		kind = $urandom_range(99);
		if (kind < 6) begin
			n = $urandom_range(18, 1);
			repeat (n) begin
				b = 8'($urandom_range(255));
				str_buf.push_back(b);
			end
			return;
		end
		if ($urandom_range(99) < 12) begin
			d = 29;
			m = 2;
		end else begin
			m = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
			if ($urandom_range(5) == 0)
				d = $urandom_range(39);
			else if (m >= 1 && m <= 12 && $urandom_range(3) == 0)
				d = MONTH_LEN[m - 1] + $urandom_range(1);
			else if (m >= 1 && m <= 12)
				d = $urandom_range(MONTH_LEN[m - 1], 1);
			else
				d = $urandom_range(31, 1);
		end
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				y = int'(min_year_cfg) + $urandom_range(6) - 3;
				if (y < 0)
					y = 0;
				if (y > 9999)
					y = 9999;
			end
			4, 5, 6: y = $urandom_range(9999);
			default: y = LEAP_PROBES[$urandom_range(8)];
		endcase
		sep = $urandom_range(1) ? CH_DASH : CH_SLASH;
		put_digits(d, (d >= 10 || $urandom_range(1)) ? 2 : 1);
		str_buf.push_back(sep);
		put_digits(m, (m >= 10 || $urandom_range(1)) ? 2 : 1);
		str_buf.push_back(sep);
		put_digits(y, 4);
		if (kind < 20) begin
			pos = $urandom_range(str_buf.size() - 1);
			case ($urandom_range(3))
				0: str_buf[pos] = (str_buf[pos] == CH_DASH) ? CH_SLASH : CH_DASH;
				1: str_buf[pos] = CH_ZERO + 8'($urandom_range(9));
				default: begin
					b = 8'($urandom_range(255));
					str_buf[pos] = b;
				end
			endcase
		end else if (kind < 32) begin
			n = $urandom_range(str_buf.size() - 1, 1);
			while (str_buf.size() > n)
				void'(str_buf.pop_back());
		end else if (kind < 42) begin
			repeat ($urandom_range(9, 1)) begin
				b = 8'($urandom_range(255));
				str_buf.push_back(b);
			end
		end else if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(2, 1)) begin
				b = $urandom_range(1) ? CH_ZERO + 8'($urandom_range(9)) : 8'($urandom_range(255));
				str_buf.push_back(b);
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (chars_pending.size() != 0 || char_ch.valid || dates_due.size() != 0);
	endtask

	task automatic write_min_year(input logic [YEAR_W-1:0] v);
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.min_year <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		min_year_cfg = v;
	endtask

	initial begin
		logic [YEAR_W-1:0] phase_min_year [6];
		arst_n = 1'b0;
		char_ch.valid = 1'b0;
		char_ch.char_in = '0;
		char_ch.last_char = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.min_year = '0;
		parse = '0;
		parse.ph = PH_D1;
		min_year_cfg = MIN_YEAR_RST;
		mismatches = 0;
		stall_cycles = 0;
		phase_chars = 0;
		send_idle_pct = 31;
		recv_idle_pct = 70;
		phase_min_year[0] = MIN_YEAR_RST;
		phase_min_year[1] = 14'd0;
		phase_min_year[2] = 14'd9999;
		phase_min_year[3] = 14'($urandom_range(9999));
		phase_min_year[4] = 14'd2000;
		phase_min_year[5] = MIN_YEAR_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				send_idle_pct = 31;
				recv_idle_pct = 70;
			end else if (p < 4) begin
				send_idle_pct = 70;
				recv_idle_pct = 31;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p != 0)
				write_min_year(phase_min_year[p]);
			if (p == 0) begin
				// leap by the 400 rule, not leap by the 100 rule, mixed separators
				send_text("29/2/2000");
				send_text("29-2-2100");
				send_text("1-1/1901");
				// lone NUL and lone 0xFF, each ending its string at once
				str_buf.push_back(8'h00);
				send_string();
				str_buf.push_back(8'hFF);
				send_string();
			end
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS) begin
				gen_random_string();
				send_string();
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (dates_due.size() != 0)
			report_mismatch($sformatf("%0d dates never delivered", dates_due.size()));
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
